// File: hw/rtl/text_console_writer_defines.svh
// Assertion macros for the text console writer checker.
// Included by tcw_checker.sv; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define TCW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
// Shared constants and types of the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;
    localparam int HISTORY_LINES_DEF  = 100;

    localparam logic [7:0] KEY_NEWLINE     = 8'd10;
    localparam logic [7:0] KEY_BACKSPACE   = 8'd8;
    localparam logic [7:0] BLANK_CHAR      = 8'h20;
    localparam logic [7:0] RESET_ATTRIBUTE = 8'h0F;

    localparam logic [1:0] FUNC_PUT          = 2'd0;
    localparam logic [1:0] FUNC_READ_SCREEN  = 2'd1;
    localparam logic [1:0] FUNC_READ_HISTORY = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ACCESS,
        ST_SCROLL,
        ST_RESP
    } tcw_state_t;

    typedef struct packed {
        logic write_cell;
        logic blank;
        logic scroll;
    } cursor_flags_t;

endpackage

// File: hw/rtl/tcw_cursor.sv
// Cursor update for one character byte: newline, backspace, print, wrap.
// Depends on tcw_pkg for key codes and the flag struct.
module tcw_cursor #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic [7:0]                        ch_i,
    input  logic [$clog2(SCREEN_ROWS)-1:0]    row_i,
    input  logic [$clog2(SCREEN_COLUMNS)-1:0] col_i,
    output logic [$clog2(SCREEN_ROWS)-1:0]    row_o,
    output logic [$clog2(SCREEN_COLUMNS)-1:0] col_o,
    output logic [$clog2(SCREEN_ROWS)-1:0]    wr_row_o,
    output logic [$clog2(SCREEN_COLUMNS)-1:0] wr_col_o,
    output tcw_pkg::cursor_flags_t            flags_o
);
    import tcw_pkg::*;

    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLUMNS);

    logic [ROW_W:0] r;
    logic [COL_W:0] c;

    always_comb begin
        r        = {1'b0, row_i};
        c        = {1'b0, col_i};
        flags_o  = '0;
        wr_row_o = row_i;
        wr_col_o = col_i;
        case (ch_i)
            KEY_NEWLINE: begin
                c = '0;
                r = r + 1'b1;
            end
            KEY_BACKSPACE: begin
                if (col_i != '0) begin
                    c = c - 1'b1;
                end else if (row_i != '0) begin
                    r = r - 1'b1;
                    c = (COL_W+1)'(SCREEN_COLUMNS - 1);
                end
                flags_o.write_cell = 1'b1;
                flags_o.blank      = 1'b1;
                wr_row_o           = ROW_W'(r);
                wr_col_o           = COL_W'(c);
            end
            default: begin
                flags_o.write_cell = 1'b1;
                c                  = c + 1'b1;
            end
        endcase
        if (c >= (COL_W+1)'(SCREEN_COLUMNS)) begin
            c = '0;
            r = r + 1'b1;
        end
        if (r >= (ROW_W+1)'(SCREEN_ROWS)) begin
            flags_o.scroll = 1'b1;
            r              = (ROW_W+1)'(SCREEN_ROWS - 1);
        end
        row_o = ROW_W'(r);
        col_o = COL_W'(c);
    end

endmodule

// File: hw/rtl/text_console_writer.sv
// Text console writer top level: screen and scrollback memories, sequencer.
// Depends on tcw_pkg and tcw_cursor.
//
// Usage:
//   s_ channel: one beat per operation. s_tuser selects put character,
//   read screen cell or read scrollback cell; s_tdata carries the character
//   and the row/line and column of a read.
//   m_ channel: one result beat per input beat, with the cell read (0 for a
//   put or an out-of-range read), the cursor, the scrollback length and
//   whether the put scrolled the screen.
//   cfg_wr_en/cfg_wr_data write the attribute byte used for new cells; write
//   it only while no operation is in flight.
// Sequence: an accepted beat passes through the MUL, ACCESS and RESP states and the
//   result is registered; a new beat is taken only once back in IDLE. The screen
//   memory port is used at most once per operation, except that a put that scrolls
//   also walks the top row through the screen read port into the scrollback memory.
// Reset: after aresetn goes high the screen is cleared one cell a cycle, all
//   SCREEN_ROWS * SCREEN_COLUMNS cells (2000 by default), with s_tready low.
// Stall: a result held by m_tready low stays stable; the next beat is still
//   accepted and processed, and it waits in the result stage until m_ frees.
module text_console_writer #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF,
    parameter int HISTORY_LINES  = tcw_pkg::HISTORY_LINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // text_attribute
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // char_code[7:0], line_index[14:8], column_index[21:15]
    input  logic [1:0]  s_tuser,       // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // cell_value[15:0], cursor_row[20:16],
                                       // cursor_column[27:21], history_length[34:28],
                                       // scrolled[35]
);
    import tcw_pkg::*;

    localparam int SCR_DEPTH  = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int HIST_DEPTH = HISTORY_LINES * SCREEN_COLUMNS;
    localparam int SCR_AW     = $clog2(SCR_DEPTH);
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int CNT_W      = $clog2(SCREEN_COLUMNS + 1);
    localparam int HS_W       = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int USED_W     = $clog2(HISTORY_LINES + 1);

    logic [7:0] in_char;
    logic [6:0] in_line;
    logic [6:0] in_col;
    assign in_char = s_tdata[7:0];
    assign in_line = s_tdata[14:8];
    assign in_col  = s_tdata[21:15];

    tcw_state_t state_reg, state_next;

    logic [7:0]         attr_reg, attr_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [HS_W-1:0]    oldest_reg, oldest_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [1:0]         func_reg, func_next;
    logic               in_range_reg, in_range_next;
    logic               write_reg, write_next;
    logic               scroll_reg, scroll_next;
    logic [7:0]         char_reg, char_next;
    logic [ROW_W-1:0]   tgt_row_reg, tgt_row_next;
    logic [COL_W-1:0]   tgt_col_reg, tgt_col_next;
    logic [HS_W-1:0]    slot_reg, slot_next;
    logic [COL_W-1:0]   hcol_reg, hcol_next;
    logic [SCR_AW-1:0]  scr_addr_reg, scr_addr_next;
    logic [HIST_AW-1:0] hist_addr_reg, hist_addr_next;
    logic [SCR_AW-1:0]  scr_rd_addr_reg, scr_rd_addr_next;
    logic [SCR_AW-1:0]  pend_addr_reg, pend_addr_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SCR_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    logic               scr_we, scr_re, hist_we, hist_re;
    logic [SCR_AW-1:0]  scr_waddr, scr_raddr;
    logic [15:0]        scr_wdata;
    logic [15:0]        scr_rdata_reg, hist_rdata_reg;
    logic [15:0]        scr_mem [SCR_DEPTH];
    logic [15:0]        hist_mem [HIST_DEPTH];

    logic               accept;
    logic [ROW_W-1:0]   cur_row, cur_col_row, cur_wr_row;
    logic [COL_W-1:0]   cur_col, cur_wr_col;
    cursor_flags_t      cur_flags;
    logic [ROW_W-1:0]   src_row, phys_row;
    logic [ROW_W:0]     row_sum;
    logic [HS_W-1:0]    src_slot, wrap_slot;
    logic [HS_W:0]      slot_sum;
    logic [15:0]        cell_out;

    tcw_cursor #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_cursor (
        .ch_i    (in_char),
        .row_i   (row_reg),
        .col_i   (col_reg),
        .row_o   (cur_row),
        .col_o   (cur_col),
        .wr_row_o(cur_wr_row),
        .wr_col_o(cur_wr_col),
        .flags_o (cur_flags)
    );
    assign cur_col_row = cur_row;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // logical row to physical row of the screen ring
    always_comb begin
        src_row = (s_tuser == FUNC_PUT) ? cur_wr_row : ROW_W'(in_line);
        row_sum = (ROW_W+1)'(top_reg) + (ROW_W+1)'(src_row);
        if (row_sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
            phys_row = ROW_W'(row_sum - (ROW_W+1)'(SCREEN_ROWS));
        end else begin
            phys_row = ROW_W'(row_sum);
        end
    end

    // scrollback slot: oldest + used for a save, oldest + line for a read
    always_comb begin
        src_slot = (s_tuser == FUNC_PUT) ? HS_W'(used_reg) : HS_W'(in_line);
        slot_sum = (HS_W+1)'(oldest_reg) + (HS_W+1)'(src_slot);
        if ((s_tuser == FUNC_PUT) && (used_reg == USED_W'(HISTORY_LINES))) begin
            wrap_slot = oldest_reg;
        end else if (slot_sum >= (HS_W+1)'(HISTORY_LINES)) begin
            wrap_slot = HS_W'(slot_sum - (HS_W+1)'(HISTORY_LINES));
        end else begin
            wrap_slot = HS_W'(slot_sum);
        end
    end

    always_comb begin
        case (func_reg)
            FUNC_READ_SCREEN:  cell_out = in_range_reg ? scr_rdata_reg : 16'h0000;
            FUNC_READ_HISTORY: cell_out = in_range_reg ? hist_rdata_reg : 16'h0000;
            default:           cell_out = 16'h0000;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == SCR_AW'(SCR_DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                if ((func_reg == FUNC_PUT) && scroll_reg) state_next = ST_SCROLL;
                else state_next = ST_RESP;
            end
            ST_SCROLL: begin
                if (cnt_reg == CNT_W'(SCREEN_COLUMNS)) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        attr_next        = cfg_wr_en ? cfg_wr_data : attr_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        top_next         = top_reg;
        oldest_next      = oldest_reg;
        used_next        = used_reg;
        func_next        = func_reg;
        in_range_next    = in_range_reg;
        write_next       = write_reg;
        scroll_next      = scroll_reg;
        char_next        = char_reg;
        tgt_row_next     = tgt_row_reg;
        tgt_col_next     = tgt_col_reg;
        slot_next        = slot_reg;
        hcol_next        = hcol_reg;
        scr_addr_next    = scr_addr_reg;
        hist_addr_next   = hist_addr_reg;
        scr_rd_addr_next = scr_rd_addr_reg;
        pend_addr_next   = pend_addr_reg;
        pend_next        = pend_reg;
        cnt_next         = cnt_reg;
        clr_addr_next    = clr_addr_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        scr_we           = 1'b0;
        scr_waddr        = scr_addr_reg;
        scr_wdata        = {attr_reg, char_reg};
        scr_re           = 1'b0;
        scr_raddr        = scr_addr_reg;
        hist_we          = 1'b0;
        hist_re          = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                scr_we        = 1'b1;
                scr_waddr     = clr_addr_reg;
                scr_wdata     = {RESET_ATTRIBUTE, BLANK_CHAR};
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    func_next     = s_tuser;
                    in_range_next = 1'b0;
                    write_next    = 1'b0;
                    scroll_next   = 1'b0;
                    tgt_row_next  = phys_row;
                    slot_next     = wrap_slot;
                    hcol_next     = '0;
                    case (s_tuser)
                        FUNC_PUT: begin
                            row_next     = cur_col_row;
                            col_next     = cur_col;
                            write_next   = cur_flags.write_cell;
                            scroll_next  = cur_flags.scroll;
                            char_next    = cur_flags.blank ? BLANK_CHAR : in_char;
                            tgt_col_next = cur_wr_col;
                        end
                        FUNC_READ_SCREEN: begin
                            in_range_next = (in_line < SCREEN_ROWS)
                                            && (in_col < SCREEN_COLUMNS);
                            tgt_col_next  = COL_W'(in_col);
                        end
                        FUNC_READ_HISTORY: begin
                            in_range_next = (in_line < used_reg)
                                            && (in_col < SCREEN_COLUMNS);
                            hcol_next     = COL_W'(in_col);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                scr_addr_next  = SCR_AW'(tgt_row_reg * SCREEN_COLUMNS + tgt_col_reg);
                hist_addr_next = HIST_AW'(slot_reg * SCREEN_COLUMNS + hcol_reg);
            end
            ST_ACCESS: begin
                case (func_reg)
                    FUNC_PUT:          scr_we  = write_reg;
                    FUNC_READ_SCREEN:  scr_re  = 1'b1;
                    FUNC_READ_HISTORY: hist_re = 1'b1;
                    default: begin
                    end
                endcase
                scr_rd_addr_next = SCR_AW'(top_reg * SCREEN_COLUMNS);
                cnt_next         = '0;
                pend_next        = 1'b0;
            end
            ST_SCROLL: begin
                // read top row cell, then save it and blank it in the next cycle
                pend_next = 1'b0;
                if (cnt_reg != CNT_W'(SCREEN_COLUMNS)) begin
                    scr_re           = 1'b1;
                    scr_raddr        = scr_rd_addr_reg;
                    pend_next        = 1'b1;
                    pend_addr_next   = scr_rd_addr_reg;
                    scr_rd_addr_next = scr_rd_addr_reg + 1'b1;
                    cnt_next         = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    hist_we        = 1'b1;
                    hist_addr_next = hist_addr_reg + 1'b1;
                    scr_we         = 1'b1;
                    scr_waddr      = pend_addr_reg;
                    scr_wdata      = {attr_reg, BLANK_CHAR};
                end
                if (cnt_reg == CNT_W'(SCREEN_COLUMNS)) begin
                    top_next = (top_reg == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_reg + 1'b1;
                    if (used_reg != USED_W'(HISTORY_LINES)) begin
                        used_next = used_reg + 1'b1;
                    end else begin
                        oldest_next = (oldest_reg == HS_W'(HISTORY_LINES - 1))
                                      ? '0 : oldest_reg + 1'b1;
                    end
                end
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000,
                                     (func_reg == FUNC_PUT) && scroll_reg,
                                     7'(used_reg),
                                     7'(col_reg),
                                     5'(row_reg),
                                     cell_out};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            attr_reg     <= RESET_ATTRIBUTE;
            row_reg      <= '0;
            col_reg      <= '0;
            top_reg      <= '0;
            oldest_reg   <= '0;
            used_reg     <= '0;
            pend_reg     <= 1'b0;
            cnt_reg      <= '0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            attr_reg     <= attr_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            top_reg      <= top_next;
            oldest_reg   <= oldest_next;
            used_reg     <= used_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg        <= func_next;
        in_range_reg    <= in_range_next;
        write_reg       <= write_next;
        scroll_reg      <= scroll_next;
        char_reg        <= char_next;
        tgt_row_reg     <= tgt_row_next;
        tgt_col_reg     <= tgt_col_next;
        slot_reg        <= slot_next;
        hcol_reg        <= hcol_next;
        scr_addr_reg    <= scr_addr_next;
        hist_addr_reg   <= hist_addr_next;
        scr_rd_addr_reg <= scr_rd_addr_next;
        pend_addr_reg   <= pend_addr_next;
        m_tdata_reg     <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
        if (scr_re) scr_rdata_reg <= scr_mem[scr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) hist_mem[hist_addr_reg] <= scr_rdata_reg;
        if (hist_re) hist_rdata_reg <= hist_mem[hist_addr_reg];
    end

endmodule

// File: hw/rtl/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_defines.svh.
`include "text_console_writer_defines.svh"

module tcw_checker #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    import tcw_pkg::*;

    `TCW_ASSERT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `TCW_ASSERT_ALWAYS(a_busy_after_reset, aclk, !aresetn |=> !s_tready, "input ready during screen clear")
    `TCW_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second beat taken while busy")
    `TCW_ASSERT(a_scroll_row, aclk, aresetn, m_tvalid && m_tdata[35] |-> m_tdata[20:16] == 5'(SCREEN_ROWS - 1), "scroll without cursor on bottom row")
    `TCW_ASSERT(a_col_range, aclk, aresetn, m_tvalid |-> (SCREEN_COLUMNS > 127) || (m_tdata[27:21] < 7'(SCREEN_COLUMNS)), "cursor column beyond screen width")

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
